// ----- hdl/ps2dl_pkg.sv -----
package ps2dl_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_QUEUE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_WAIT      = 4'd1,
      ST_INHIBIT   = 4'd2,
      ST_TX_BIT    = 4'd3,
      ST_TX_PARITY = 4'd4,
      ST_TX_STOP   = 4'd5,
      ST_RX_BIT    = 4'd6,
      ST_RX_PARITY = 4'd7,
      ST_RX_ACK    = 4'd8,
      ST_RX_END    = 4'd9
   } link_state_type;

   localparam logic [7:0] RESEND_CODE = 8'hFE;
   localparam logic [7:0] RX_MSB      = 8'h80;
   localparam logic [3:0] BITS_BYTE   = 4'd8;

endpackage

// ----- hdl/ps2dl_ram.sv -----
module ps2dl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ps2_device_link_engine.sv -----
// An accepted req item has its rsp item registered, and it appears in the next cycle.
// Throughput: one item per cycle; req_stall rises only while a finished
// rsp item is held by rsp_stall.
// The send queue lives in a RAM with a registered read, prefetched at the
// next read pointer each cycle, with a bypass for a write to that entry.
// Synchronous reset clears all control state; queue contents are not cleared.
module ps2_device_link_engine #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ps2dl_pkg::op_type     req_operation,
   input  logic [7:0]            req_send_byte,
   input  logic                  req_clock_sensed_low,
   input  logic                  req_data_sensed_high,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clock_drive_low,
   output logic                  rsp_data_drive_low,
   output logic                  rsp_received_valid,
   output logic [7:0]            rsp_received_byte,
   output logic                  rsp_parity_error,
   output logic                  rsp_send_error,
   output logic                  rsp_queue_overflow,
   output logic [4:0]            rsp_queue_count
);

   import ps2dl_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

   // link state
   logic [1:0]     phase_ff, phase_in;
   link_state_type state_ff, state_in;
   logic           clock_en_ff, clock_en_in;
   logic [7:0]     shift_ff, shift_in;
   logic [3:0]     bits_left_ff, bits_left_in;
   logic           parity_ff, parity_in;
   logic           send_err_ff, send_err_in;
   logic           clock_low_ff, clock_low_in;
   logic           data_low_ff, data_low_in;

   // queue
   logic [QW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           bypass_hit_ff, bypass_hit_in;
   logic [7:0]     bypass_data_ff;
   logic           wr_en;
   logic [QW-1:0]  ram_rd_addr;
   logic [7:0]     ram_q;
   logic [7:0]     head_byte;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_clock_ff, rsp_data_ff, rsp_rx_valid_ff, rsp_perr_ff;
   logic           rsp_send_err_ff, rsp_ovf_ff;
   logic [7:0]     rsp_byte_ff;
   logic [4:0]     rsp_count_ff;

   logic           req_accept;
   logic           res_rx_valid, res_perr, res_ovf;
   logic [7:0]     res_byte;
   logic [3:0]     bits_dec;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign bits_dec   = bits_left_ff - 4'd1;
   assign head_byte  = bypass_hit_ff ? bypass_data_ff : ram_q;

   always_comb begin
      phase_in     = phase_ff;
      state_in     = state_ff;
      clock_en_in  = clock_en_ff;
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      parity_in    = parity_ff;
      send_err_in  = send_err_ff;
      clock_low_in = clock_low_ff;
      data_low_in  = data_low_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      wr_en        = 1'b0;
      res_rx_valid = 1'b0;
      res_perr     = 1'b0;
      res_ovf      = 1'b0;
      res_byte     = 8'd0;

      if (req_accept) begin
         unique case (req_operation)
            OP_TICK: begin
               phase_in = phase_ff + 2'd1;
               if (phase_ff[0]) begin
                  if (phase_ff[1]) begin
                     // machine steps in the middle of the high half
                     unique case (state_ff)
                        ST_WAIT: begin
                           if (req_clock_sensed_low) begin
                              state_in = ST_INHIBIT;
                           end else if (!send_err_ff && fill_ff != '0) begin
                              data_low_in  = 1'b1;
                              clock_en_in  = 1'b1;
                              shift_in     = head_byte;
                              rd_ptr_in    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
                              fill_in      = fill_ff - 1'b1;
                              parity_in    = 1'b0;
                              bits_left_in = BITS_BYTE;
                              state_in     = ST_TX_BIT;
                           end
                        end
                        ST_INHIBIT: begin
                           if (!req_clock_sensed_low) begin
                              if (req_data_sensed_high) begin
                                 state_in = ST_IDLE;
                              end else begin
                                 // host request to send
                                 parity_in    = 1'b0;
                                 bits_left_in = BITS_BYTE;
                                 clock_en_in  = 1'b1;
                                 state_in     = ST_RX_BIT;
                              end
                           end
                        end
                        ST_TX_BIT: begin
                           if (req_clock_sensed_low) begin
                              data_low_in = 1'b0;
                              send_err_in = 1'b1;
                              state_in    = ST_INHIBIT;
                           end else begin
                              data_low_in  = !shift_ff[0];
                              parity_in    = parity_ff ^ shift_ff[0];
                              shift_in     = {1'b0, shift_ff[7:1]};
                              bits_left_in = bits_dec;
                              state_in     = (bits_dec != 4'd0) ? ST_TX_BIT : ST_TX_PARITY;
                           end
                        end
                        ST_TX_PARITY: begin
                           if (req_clock_sensed_low) begin
                              data_low_in = 1'b0;
                              send_err_in = 1'b1;
                              state_in    = ST_INHIBIT;
                           end else begin
                              data_low_in = parity_ff;
                              state_in    = ST_TX_STOP;
                           end
                        end
                        ST_TX_STOP: begin
                           data_low_in = 1'b0;
                           state_in    = ST_IDLE;
                        end
                        ST_RX_BIT: begin
                           shift_in     = {1'b0, shift_ff[7:1]} |
                                          (req_data_sensed_high ? RX_MSB : 8'd0);
                           parity_in    = parity_ff ^ req_data_sensed_high;
                           bits_left_in = bits_dec;
                           state_in     = (bits_dec != 4'd0) ? ST_RX_BIT : ST_RX_PARITY;
                        end
                        ST_RX_PARITY: begin
                           parity_in = parity_ff ^ req_data_sensed_high;
                           state_in  = ST_RX_ACK;
                        end
                        ST_RX_ACK: begin
                           if (req_data_sensed_high) begin
                              data_low_in = 1'b1;
                              state_in    = ST_RX_END;
                              if (!parity_ff) begin
                                 res_rx_valid = 1'b1;
                                 res_perr     = 1'b1;
                              end else if (shift_ff == RESEND_CODE) begin
                                 // step back to the last sent byte
                                 if (fill_ff != FILL_MAX) begin
                                    rd_ptr_in = (rd_ptr_ff == '0) ? PTR_LAST : rd_ptr_ff - 1'b1;
                                    fill_in   = fill_ff + 1'b1;
                                 end
                              end else begin
                                 res_rx_valid = 1'b1;
                                 res_byte     = shift_ff;
                              end
                           end
                        end
                        ST_RX_END: begin
                           data_low_in = 1'b0;
                           clock_en_in = 1'b0;
                           state_in    = req_clock_sensed_low ? ST_INHIBIT : ST_WAIT;
                        end
                        default: begin
                           clock_en_in = 1'b0;
                           state_in    = req_clock_sensed_low ? ST_INHIBIT : ST_WAIT;
                        end
                     endcase
                  end
               end else if (clock_en_ff) begin
                  clock_low_in = !phase_ff[1];
               end
            end
            OP_QUEUE: begin
               if (fill_ff == FILL_MAX) begin
                  res_ovf = 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
            end
            OP_CLEAR: begin
               send_err_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // prefetch the entry the read pointer will hold next cycle
   assign ram_rd_addr   = reset ? '0 : rd_ptr_in;
   assign bypass_hit_in = wr_en && (wr_ptr_ff == ram_rd_addr);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   ps2dl_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_send_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 2'd1;
         state_ff      <= ST_IDLE;
         clock_en_ff   <= 1'b0;
         shift_ff      <= 8'd0;
         bits_left_ff  <= 4'd0;
         parity_ff     <= 1'b0;
         send_err_ff   <= 1'b0;
         clock_low_ff  <= 1'b0;
         data_low_ff   <= 1'b0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         bypass_hit_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         state_ff      <= state_in;
         clock_en_ff   <= clock_en_in;
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         parity_ff     <= parity_in;
         send_err_ff   <= send_err_in;
         clock_low_ff  <= clock_low_in;
         data_low_ff   <= data_low_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_ff       <= fill_in;
         bypass_hit_ff <= bypass_hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= req_send_byte;
      if (req_accept) begin
         rsp_clock_ff    <= clock_low_in;
         rsp_data_ff     <= data_low_in;
         rsp_rx_valid_ff <= res_rx_valid;
         rsp_byte_ff     <= res_byte;
         rsp_perr_ff     <= res_perr;
         rsp_send_err_ff <= send_err_in;
         rsp_ovf_ff      <= res_ovf;
         rsp_count_ff    <= 5'(fill_in);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_clock_drive_low = rsp_clock_ff;
   assign rsp_data_drive_low  = rsp_data_ff;
   assign rsp_received_valid  = rsp_rx_valid_ff;
   assign rsp_received_byte   = rsp_byte_ff;
   assign rsp_parity_error    = rsp_perr_ff;
   assign rsp_send_error      = rsp_send_err_ff;
   assign rsp_queue_overflow  = rsp_ovf_ff;
   assign rsp_queue_count     = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("send queue fill beyond depth");

   a_enqueue_counts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_operation == OP_QUEUE && fill_ff != FILL_MAX
      |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("enqueue did not advance fill");

   a_clock_held: assert property (@(posedge clock) disable iff (reset)
      !clock_en_ff |=> clock_low_ff == $past(clock_low_ff))
      else $error("clock drive changed while clock disabled");

   a_perr_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_perr_ff |-> rsp_rx_valid_ff && rsp_byte_ff == 8'd0)
      else $error("parity error without a delivered reception");

endmodule

// ----- tb/sv/tb_ps2_device_link_engine.sv -----
module tb_ps2_device_link_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ps2dl_pkg::*;

   localparam int RANDOM_ITEMS = 1325;
   localparam int PROFILE_ITEMS = 150;
   localparam int CYCLE_LIMIT = 200000;
   localparam int FIFO_DEPTH = 16;
   localparam logic [7:0] FILL_BYTES [FIFO_DEPTH] = '{
      8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F,
      8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h96, 8'h69, 8'h11, 8'hEE
   };

   typedef struct packed {
      logic       clk_lo;
      logic       dat_lo;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       par_err;
      logic       send_err;
      logic       ovf;
      logic [4:0] count;
   } line_status_type;

   typedef struct {
      op_type          op;
      logic [7:0]      b;
      logic            cl;
      logic            dh;
      bit              typed;
      line_status_type wanted;
   } plan_row_type;

   typedef enum {HOST_IDLE, HOST_NOISE, HOST_FRAME} host_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   op_type     req_operation = OP_NONE;
   logic [7:0] req_send_byte = 8'h00;
   logic       req_clock_sensed_low = 1'b0;
   logic       req_data_sensed_high = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_clock_drive_low;
   logic       rsp_data_drive_low;
   logic       rsp_received_valid;
   logic [7:0] rsp_received_byte;
   logic       rsp_parity_error;
   logic       rsp_send_error;
   logic       rsp_queue_overflow;
   logic [4:0] rsp_queue_count;

   ps2_device_link_engine dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_send_byte        (req_send_byte),
      .req_clock_sensed_low (req_clock_sensed_low),
      .req_data_sensed_high (req_data_sensed_high),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_clock_drive_low  (rsp_clock_drive_low),
      .rsp_data_drive_low   (rsp_data_drive_low),
      .rsp_received_valid   (rsp_received_valid),
      .rsp_received_byte    (rsp_received_byte),
      .rsp_parity_error     (rsp_parity_error),
      .rsp_send_error       (rsp_send_error),
      .rsp_queue_overflow   (rsp_queue_overflow),
      .rsp_queue_count      (rsp_queue_count)
   );

   always #6 clock = ~clock;

   // link engine model state
   logic [1:0]     ph = 2'd1;
   link_state_type lst = ST_IDLE;
   logic           clk_en = 1'b0;
   logic [7:0]     shreg = 8'h00;
   logic [3:0]     bleft = 4'd0;
   logic           par = 1'b0;
   logic           serr = 1'b0;
   logic [7:0]     sq [FIFO_DEPTH];
   logic [3:0]     rdp = 4'd0;
   logic [3:0]     wrp = 4'd0;
   logic [4:0]     fill = 5'd0;
   logic           clk_lo = 1'b0;
   logic           dat_lo = 1'b0;

   line_status_type pending_status [$];
   int mismatches = 0;
   int checked = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   // host side of the link
   host_mode_type host = HOST_IDLE;
   int         ticks_left = 0;
   int         inhibit_left = 0;
   int         ack_hold = 0;
   int         burst_left = 0;
   bit         want_burst = 0;
   bit         frame_req = 0;
   bit         frame_rx = 0;
   bit         frame_bad_parity = 0;
   logic [7:0] frame_byte = 8'h00;

   function automatic line_status_type step_link(op_type op, logic [7:0] b_in,
                                                 logic clk_low, logic dat_high);
      line_status_type s;
      s = '0;
      case (op)
         OP_TICK: begin
            if (ph[0]) begin
               if (ph[1]) begin
                  case (lst)
                     ST_WAIT: begin
                        if (clk_low) lst = ST_INHIBIT;
                        else if (!serr && fill != 5'd0) begin
                           dat_lo = 1'b1;
                           clk_en = 1'b1;
                           shreg = sq[rdp];
                           rdp++;
                           fill--;
                           par = 1'b0;
                           bleft = BITS_BYTE;
                           lst = ST_TX_BIT;
                        end
                     end
                     ST_INHIBIT: begin
                        if (!clk_low) begin
                           if (dat_high) lst = ST_IDLE;
                           else begin
                              par = 1'b0;
                              bleft = BITS_BYTE;
                              clk_en = 1'b1;
                              lst = ST_RX_BIT;
                           end
                        end
                     end
                     ST_TX_BIT, ST_TX_PARITY: begin
                        if (clk_low) begin
                           // host pulled the clock mid-transmission
                           dat_lo = 1'b0;
                           serr = 1'b1;
                           lst = ST_INHIBIT;
                        end else if (lst == ST_TX_PARITY) begin
                           dat_lo = par;
                           lst = ST_TX_STOP;
                        end else begin
                           dat_lo = ~shreg[0];
                           par ^= shreg[0];
                           shreg = shreg >> 1;
                           bleft--;
                           if (bleft == 4'd0) lst = ST_TX_PARITY;
                        end
                     end
                     ST_TX_STOP: begin
                        dat_lo = 1'b0;
                        lst = ST_IDLE;
                     end
                     ST_RX_BIT: begin
                        shreg = {dat_high, shreg[7:1]};
                        par ^= dat_high;
                        bleft--;
                        if (bleft == 4'd0) lst = ST_RX_PARITY;
                     end
                     ST_RX_PARITY: begin
                        par ^= dat_high;
                        lst = ST_RX_ACK;
                     end
                     ST_RX_ACK: begin
                        if (dat_high) begin
                           dat_lo = 1'b1;
                           if (!par) begin
                              s.rx_valid = 1'b1;
                              s.par_err = 1'b1;
                           end else if (shreg != RESEND_CODE) begin
                              s.rx_valid = 1'b1;
                              s.rx_byte = shreg;
                           end else if (fill < FIFO_DEPTH) begin
                              // resend: step back to the last byte sent
                              rdp--;
                              fill++;
                           end
                           lst = ST_RX_END;
                        end
                     end
                     default: begin
                        if (lst == ST_RX_END) dat_lo = 1'b0;
                        clk_en = 1'b0;
                        lst = clk_low ? ST_INHIBIT : ST_WAIT;
                     end
                  endcase
               end
            end else if (clk_en) begin
               clk_lo = ~ph[1];
            end
            ph = ph + 2'd1;
         end
         OP_QUEUE: begin
            if (fill >= FIFO_DEPTH) s.ovf = 1'b1;
            else begin
               sq[wrp] = b_in;
               wrp++;
               fill++;
            end
         end
         OP_CLEAR: serr = 1'b0;
         default: ;
      endcase
      s.clk_lo = clk_lo;
      s.dat_lo = dat_lo;
      s.send_err = serr;
      s.count = fill;
      return s;
   endfunction

   // Next item: mostly a host that follows the link protocol, plus noise,
   // queue requests, error clears and unused operations.
   task automatic pick_item(output op_type op, output logic [7:0] b_out,
                            output logic cl, output logic dh);
      int r;
      op = OP_TICK;
      b_out = 8'($urandom);
      cl = 1'($urandom);
      dh = 1'($urandom);
      r = $urandom_range(99);
      if (burst_left > 0) begin
         burst_left--;
         op = OP_QUEUE;
      end else if (r < 4) begin
         op = OP_QUEUE;
      end else if (r < 6) begin
         op = OP_CLEAR;
      end else if (r < 7) begin
         op = OP_NONE;
      end else begin
         if (host == HOST_FRAME && frame_rx &&
             !(lst inside {ST_RX_BIT, ST_RX_PARITY, ST_RX_ACK, ST_RX_END}))
            ticks_left = 0;
         if (ticks_left == 0) begin
            r = $urandom_range(99);
            frame_req = 0;
            frame_rx = 0;
            if (r < 45) begin
               host = HOST_FRAME;
               ticks_left = 1;
               frame_byte = ($urandom_range(2) == 0) ? RESEND_CODE : 8'($urandom);
               frame_bad_parity = ($urandom_range(4) == 0);
               inhibit_left = $urandom_range(16, 4);
               ack_hold = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : 0;
               want_burst = ($urandom_range(3) == 0);
            end else if (r < 85) begin
               host = HOST_IDLE;
               ticks_left = $urandom_range(80, 10);
            end else begin
               host = HOST_NOISE;
               ticks_left = $urandom_range(40, 5);
            end
         end
         case (host)
            HOST_IDLE: begin
               cl = 1'b0;
               dh = 1'b1;
               ticks_left--;
            end
            HOST_NOISE: ticks_left--;
            default: begin
               if (frame_req && lst == ST_RX_BIT) frame_rx = 1;
               if (frame_rx) begin
                  cl = 1'b0;
                  case (lst)
                     ST_RX_BIT:    dh = frame_byte[8 - int'(bleft)];
                     ST_RX_PARITY: dh = ~(^frame_byte) ^ frame_bad_parity;
                     ST_RX_ACK: begin
                        dh = (ack_hold == 0);
                        if (ack_hold > 0) ack_hold--;
                     end
                     default:      dh = 1'b1;
                  endcase
               end else if (inhibit_left > 0 || lst != ST_INHIBIT) begin
                  cl = 1'b1;
                  dh = 1'b1;
                  if (inhibit_left > 0) inhibit_left--;
                  // fill the queue while the host holds the link, so a
                  // resend can land on a full queue
                  if (want_burst && lst == ST_INHIBIT) begin
                     want_burst = 0;
                     burst_left = FIFO_DEPTH + 1;
                  end
               end else begin
                  // request to send: clock released, data held low
                  cl = 1'b0;
                  dh = 1'b0;
                  frame_req = 1;
               end
            end
         endcase
      end
   endtask

   task automatic offer_item(op_type op, logic [7:0] b_in, logic cl, logic dh,
                             bit typed, line_status_type wanted);
      line_status_type predicted;
      predicted = step_link(op, b_in, cl, dh);
      pending_status.push_back(typed ? wanted : predicted);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_send_byte <= b_in;
      req_clock_sensed_low <= cl;
      req_data_sensed_high <= dh;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      if (mismatches < 40)
         $display("mismatch at item %0d, %s: got %0h, expected %0h",
                  checked, field, got, want);
      mismatches++;
   endtask

   function automatic plan_row_type make_row(op_type op, logic [7:0] b_in, logic cl,
                                             logic dh, bit typed, logic ovf,
                                             logic [4:0] count);
      plan_row_type row;
      row.op = op;
      row.b = b_in;
      row.cl = cl;
      row.dh = dh;
      row.typed = typed;
      row.wanted = '0;
      row.wanted.ovf = ovf;
      row.wanted.count = count;
      return row;
   endfunction

   always @(posedge clock) begin
      line_status_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            report_mismatch("item with nothing expected", 0, 0);
         end else begin
            wanted = pending_status.pop_front();
            if (rsp_clock_drive_low !== wanted.clk_lo)
               report_mismatch("clock_drive_low", rsp_clock_drive_low, wanted.clk_lo);
            if (rsp_data_drive_low !== wanted.dat_lo)
               report_mismatch("data_drive_low", rsp_data_drive_low, wanted.dat_lo);
            if (rsp_received_valid !== wanted.rx_valid)
               report_mismatch("received_valid", rsp_received_valid, wanted.rx_valid);
            if (rsp_received_byte !== wanted.rx_byte)
               report_mismatch("received_byte", rsp_received_byte, wanted.rx_byte);
            if (rsp_parity_error !== wanted.par_err)
               report_mismatch("parity_error", rsp_parity_error, wanted.par_err);
            if (rsp_send_error !== wanted.send_err)
               report_mismatch("send_error", rsp_send_error, wanted.send_err);
            if (rsp_queue_overflow !== wanted.ovf)
               report_mismatch("queue_overflow", rsp_queue_overflow, wanted.ovf);
            if (rsp_queue_count !== wanted.count)
               report_mismatch("queue_count", rsp_queue_count, wanted.count);
         end
         checked++;
      end
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ps2_device_link_engine regression: fail");
         $finish;
      end
   end

   initial begin
      plan_row_type plan [$];
      op_type       op;
      logic [7:0]   b_out;
      logic         cl;
      logic         dh;
      int           counted;
      int           profile;

      plan.push_back(make_row(OP_NONE, 8'hFF, 1'b1, 1'b1, 1, 1'b0, 5'd0));
      plan.push_back(make_row(OP_CLEAR, 8'h00, 1'b0, 1'b0, 1, 1'b0, 5'd0));
      // writing every queue entry once keeps a later resend off unwritten entries
      foreach (FILL_BYTES[i])
         plan.push_back(make_row(OP_QUEUE, FILL_BYTES[i], i[0], i[1], 1, 1'b0,
                                 5'(i + 1)));
      plan.push_back(make_row(OP_QUEUE, 8'hA5, 1'b0, 1'b1, 1, 1'b1, 5'd16));
      plan.push_back(make_row(OP_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b0, 5'd16));
      plan.push_back(make_row(OP_TICK, 8'hFF, 1'b1, 1'b0, 1, 1'b0, 5'd16));
      plan.push_back(make_row(OP_TICK, 8'h00, 1'b1, 1'b1, 1, 1'b0, 5'd16));
      repeat (4) plan.push_back(make_row(OP_TICK, 8'h5A, 1'b0, 1'b1, 0, 1'b0, 5'd0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         offer_item(plan[i].op, plan[i].b, plan[i].cl, plan[i].dh,
                    plan[i].typed, plan[i].wanted);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         profile = (counted / PROFILE_ITEMS) % 4;
         gap_pct = (profile == 1) ? 84 : (profile == 3) ? 8 : 0;
         stall_pct = (profile == 2) ? 84 : (profile == 3) ? 8 : 0;
         pick_item(op, b_out, cl, dh);
         offer_item(op, b_out, cl, dh, 0, '0);
         if (op != OP_NONE) counted++;
      end

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("ps2_device_link_engine regression: pass");
      else
         $display("ps2_device_link_engine regression: fail");
      $finish;
   end

endmodule
